// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/mahd_pkg.sv =====
// ----------------------------------------------------------------------------
// mahd_pkg
// Field codes, widths and rate/bitrate tables for the audio header decoder.
// ----------------------------------------------------------------------------
package mahd_pkg;

    localparam int HdrW     = 32;
    localparam int FrameW   = 11;
    localparam int RateW    = 16;
    localparam int KbpsW    = 9;
    localparam int ChanW    = 2;
    localparam int KmulW    = 18;   // holds 144000
    localparam int NumW     = 27;   // K * kbps * 4 stays below 2^27
    localparam int QW       = 12;   // quotient below 4096
    localparam int RecipW   = 13;
    localparam int RecipSh  = 27;   // reciprocal scale, >= NumW keeps error under one
    localparam int ProdW    = NumW + RecipW;
    localparam int SumW     = QW + 2;
    localparam int TdataW   = ((FrameW + RateW + KbpsW + ChanW + 7) / 8) * 8;
    localparam int PadW     = TdataW - (FrameW + RateW + KbpsW + ChanW);

    localparam logic [HdrW-1:0]   SYNC_MASK = 32'hffe0_0000;
    localparam logic [3:0]        BIDX_FREE = 4'h0;
    localparam logic [3:0]        BIDX_BAD  = 4'hf;
    localparam logic [1:0]        SIDX_RSV  = 2'd3;
    localparam logic [1:0]        MODE_MONO = 2'd3;
    localparam logic [FrameW-1:0] FRAME_MAX = 11'd2047;

    localparam logic [KmulW-1:0] K_L1      = 18'd12000;
    localparam logic [KmulW-1:0] K_L2      = 18'd144000;
    localparam logic [KmulW-1:0] K_L3_LSF  = 18'd72000;

    localparam logic [ChanW-1:0] CHAN_MONO   = 2'd1;
    localparam logic [ChanW-1:0] CHAN_STEREO = 2'd2;

    typedef enum logic [1:0] {
        VER_25  = 2'd0,
        VER_RSV = 2'd1,
        VER_2   = 2'd2,
        VER_1   = 2'd3
    } mpeg_ver_t;

    typedef enum logic [1:0] {
        LAYER_RSV = 2'd0,
        LAYER_3   = 2'd1,
        LAYER_2   = 2'd2,
        LAYER_1   = 2'd3
    } mpeg_layer_t;

    // fields carried unchanged down the pipe
    typedef struct packed {
        logic             ok;
        logic [KbpsW-1:0] kbps;
        logic [RateW-1:0] rate;
        logic [1:0]       sidx;
        logic             pad;
        logic             lay1;
        logic             mono;
    } side_t;

    typedef logic [KbpsW-1:0] kbps_tab_t [16];

    localparam kbps_tab_t KBPS_V1_L1 = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
        9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam kbps_tab_t KBPS_V2_L1 = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
        9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam kbps_tab_t KBPS_V1_L2 = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
        9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam kbps_tab_t KBPS_V1_L3 = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
        9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam kbps_tab_t KBPS_V2_L23 = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
        9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

    function automatic logic [RateW-1:0] base_rate(input logic [1:0] sidx);
        logic [RateW-1:0] r;
        unique case (sidx)
            2'd0:    r = 16'd44100;
            2'd1:    r = 16'd48000;
            2'd2:    r = 16'd32000;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // floor(2^RecipSh / base rate)
    function automatic logic [RecipW-1:0] base_recip(input logic [1:0] sidx);
        logic [RecipW-1:0] r;
        unique case (sidx)
            2'd0:    r = 13'd3043;
            2'd1:    r = 13'd2796;
            2'd2:    r = 13'd4194;
            default: r = 13'd0;
        endcase
        return r;
    endfunction

    function automatic logic [KbpsW-1:0] kbps_lookup(input logic is_v1,
                                                     input mpeg_layer_t lay,
                                                     input logic [3:0] bidx);
        logic [KbpsW-1:0] k;
        unique case (lay)
            LAYER_1: k = is_v1 ? KBPS_V1_L1[bidx] : KBPS_V2_L1[bidx];
            LAYER_2: k = is_v1 ? KBPS_V1_L2[bidx] : KBPS_V2_L23[bidx];
            LAYER_3: k = is_v1 ? KBPS_V1_L3[bidx] : KBPS_V2_L23[bidx];
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/mpeg_audio_header_decode_core.sv =====
// ----------------------------------------------------------------------------
// mpeg_audio_header_decode_core
// Decodes one 32-bit audio frame header per item into validity, frame length,
// sample rate, bitrate and channel count.
// ----------------------------------------------------------------------------
// Takes one header and returns one result per clock while the output is ready.
// The stages carry out the frame-length division by the sample rate, done as
// a reciprocal multiply (header decode, numerator multiply, reciprocal
// multiply, back-multiply, remainder correction into the output register).
// Each stage holds its item while the next one is full and cannot move, so
// bubbles close up and a stalled output still lets new headers in while any
// stage is empty. Rejected headers give m_axis_tuser = 0 and all-zero tdata.
module mpeg_audio_header_decode_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mahd_pkg::HdrW-1:0]       s_axis_tdata,   // header_word[31:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // frame_bytes[10:0], sample_rate_hz[26:11], bitrate_kbps[35:27],
    // channel_count[37:36], zero fill [39:38]
    output logic [mahd_pkg::TdataW-1:0]     m_axis_tdata,
    output logic                            m_axis_tuser    // header_valid
);
    import mahd_pkg::*;

    localparam int NumStg = 5;

    logic [NumStg-1:0] vld_reg;
    logic [NumStg-1:0] vld_next;
    logic [NumStg:0]   rdy;
    logic [NumStg-1:0] vin;

    // stage payloads
    side_t             s1_side_reg, s2_side_reg, s3_side_reg, s4_side_reg;
    logic [KmulW-1:0]  s1_kmul_reg;
    logic [1:0]        s1_dsh_reg;
    logic [NumW-1:0]   s2_num_reg, s3_num_reg, s4_num_reg;
    logic [QW-1:0]     s3_q_reg, s4_q_reg;
    logic [NumW-1:0]   s4_prod_reg;
    logic              out_ok_reg;
    logic [FrameW-1:0] out_frame_reg;
    logic [RateW-1:0]  out_rate_reg;
    logic [KbpsW-1:0]  out_kbps_reg;
    logic [ChanW-1:0]  out_chan_reg;

    // handshake: a stage loads when empty or when its successor moves
    always_comb begin
        rdy[NumStg] = m_axis_tready;
        for (int k = NumStg - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vin[0] = s_axis_tvalid;
        for (int k = 1; k < NumStg; k++) begin
            vin[k] = vld_reg[k-1];
        end
        for (int k = 0; k < NumStg; k++) begin
            vld_next[k] = rdy[k] ? vin[k] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: field decode, checks, table lookups
    mpeg_ver_t   ver;
    mpeg_layer_t lay;
    logic [3:0]  bidx;
    logic [1:0]  sidx;
    logic        is_v1;
    side_t       s1_side_next;
    logic [KmulW-1:0] s1_kmul_next;
    logic [1:0]  s1_dsh_next;

    always_comb begin
        ver   = mpeg_ver_t'(s_axis_tdata[20:19]);
        lay   = mpeg_layer_t'(s_axis_tdata[18:17]);
        bidx  = s_axis_tdata[15:12];
        sidx  = s_axis_tdata[11:10];
        is_v1 = (ver == VER_1);

        unique case (ver)
            VER_2:   s1_dsh_next = 2'd1;
            VER_25:  s1_dsh_next = 2'd2;
            default: s1_dsh_next = 2'd0;
        endcase

        unique case (lay)
            LAYER_1: s1_kmul_next = K_L1;
            LAYER_3: s1_kmul_next = is_v1 ? K_L2 : K_L3_LSF;
            default: s1_kmul_next = K_L2;
        endcase

        s1_side_next.ok   = ((s_axis_tdata & SYNC_MASK) == SYNC_MASK) && (ver != VER_RSV)
                            && (lay != LAYER_RSV) && (bidx != BIDX_FREE)
                            && (bidx != BIDX_BAD) && (sidx != SIDX_RSV);
        s1_side_next.kbps = kbps_lookup(is_v1, lay, bidx);
        s1_side_next.rate = base_rate(sidx) >> s1_dsh_next;
        s1_side_next.sidx = sidx;
        s1_side_next.pad  = s_axis_tdata[9];
        s1_side_next.lay1 = (lay == LAYER_1);
        s1_side_next.mono = (s_axis_tdata[7:6] == MODE_MONO);
    end

    // stage 2 numerator: K * kbps * (base / rate), so the divisor is a base rate
    logic [KmulW+KbpsW-1:0] kk_prod;
    logic [NumW-1:0]        s2_num_next;
    // stage 3: estimate within one below the true quotient
    logic [ProdW-1:0]       recip_prod;
    logic [QW-1:0]          s3_q_next;
    // stage 4
    logic [QW+RateW-1:0]    back_prod;
    logic [NumW-1:0]        s4_prod_next;
    // stage 5
    logic [NumW-1:0]        rem;
    logic                   q_inc;
    logic [SumW-1:0]        q_sum;
    logic [SumW-1:0]        bytes;
    logic [FrameW-1:0]      frame_sat;

    always_comb begin
        kk_prod      = s1_kmul_reg * s1_side_reg.kbps;
        s2_num_next  = NumW'(kk_prod) << s1_dsh_reg;

        recip_prod   = s2_num_reg * base_recip(s2_side_reg.sidx);
        s3_q_next    = QW'(recip_prod >> RecipSh);

        back_prod    = s3_q_reg * base_rate(s3_side_reg.sidx);
        s4_prod_next = NumW'(back_prod);

        rem       = s4_num_reg - s4_prod_reg;
        q_inc     = (rem >= {{(NumW-RateW){1'b0}}, base_rate(s4_side_reg.sidx)});
        q_sum     = {2'b00, s4_q_reg} + {{(SumW-1){1'b0}}, q_inc}
                    + {{(SumW-1){1'b0}}, s4_side_reg.pad};
        bytes     = s4_side_reg.lay1 ? (q_sum << 2) : q_sum;
        frame_sat = (bytes > {{(SumW-FrameW){1'b0}}, FRAME_MAX}) ? FRAME_MAX
                                                                : FrameW'(bytes);
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && vin[0]) begin
            s1_side_reg <= s1_side_next;
            s1_kmul_reg <= s1_kmul_next;
            s1_dsh_reg  <= s1_dsh_next;
        end
        if (rdy[1] && vin[1]) begin
            s2_side_reg <= s1_side_reg;
            s2_num_reg  <= s2_num_next;
        end
        if (rdy[2] && vin[2]) begin
            s3_side_reg <= s2_side_reg;
            s3_num_reg  <= s2_num_reg;
            s3_q_reg    <= s3_q_next;
        end
        if (rdy[3] && vin[3]) begin
            s4_side_reg <= s3_side_reg;
            s4_num_reg  <= s3_num_reg;
            s4_q_reg    <= s3_q_reg;
            s4_prod_reg <= s4_prod_next;
        end
        if (rdy[4] && vin[4]) begin
            out_ok_reg    <= s4_side_reg.ok;
            out_frame_reg <= s4_side_reg.ok ? frame_sat : '0;
            out_rate_reg  <= s4_side_reg.ok ? s4_side_reg.rate : '0;
            out_kbps_reg  <= s4_side_reg.ok ? s4_side_reg.kbps : '0;
            out_chan_reg  <= !s4_side_reg.ok ? '0 :
                             (s4_side_reg.mono ? CHAN_MONO : CHAN_STEREO);
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = vld_reg[NumStg-1];
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tdata  = {{PadW{1'b0}}, out_chan_reg, out_kbps_reg, out_rate_reg,
                            out_frame_reg};

`include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_fills_stage1, aclk, aresetn,
                 s_axis_tvalid && s_axis_tready, vld_reg[0])
    `ASSERT_IMPL(a_reject_all_zero, aclk, aresetn,
                 m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
    `ASSERT_IMPL(a_valid_fields_set, aclk, aresetn, m_axis_tvalid && m_axis_tuser,
                 (out_frame_reg != '0) && (out_kbps_reg != '0) && (out_chan_reg != '0)
                 && (out_rate_reg >= 16'd8000))

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the audio frame header decoder: a directed set of
// headers (every reject reason, each version/layer pair, padding, mono, frame
// length limits) followed by random well-formed, broken and noise headers,
// with bursty input, a patterned output stall and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mahd_pkg::*;

    localparam int NUM_HEADERS = 1300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 400;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic              valid;
        logic [FrameW-1:0] frame_bytes;
        logic [RateW-1:0]  rate_hz;
        logic [KbpsW-1:0]  kbps;
        logic [ChanW-1:0]  chans;
    } header_info_t;

    typedef struct {
        logic [HdrW-1:0] hdr;
        header_info_t    info;
    } decode_entry_t;

    typedef enum int {
        TAB_V1_L1, TAB_V2_L1, TAB_V1_L2, TAB_V1_L3, TAB_V2_L23
    } kbps_tab_e;

    typedef enum int {
        BRK_SYNC, BRK_VER, BRK_LAYER, BRK_FREE, BRK_BAD, BRK_SIDX
    } header_fault_e;

    class header_scoreboard;
        decode_entry_t pending_q[$];
        int            errors;
        // kbps per bitrate index 1..14
        int unsigned   kbps_tab [5][14] = '{
            '{32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
            '{32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
            '{32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
            '{32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320},
            '{8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160}
        };

        function header_info_t decode_header(logic [HdrW-1:0] h);
            header_info_t info;
            mpeg_ver_t    ver;
            mpeg_layer_t  lay;
            logic [3:0]   bidx;
            logic [1:0]   sidx;
            logic [1:0]   mode;
            logic         v1;
            int unsigned  rate;
            int unsigned  kbps;
            int unsigned  bytes;
            kbps_tab_e    sel;
            info = '0;
            ver  = mpeg_ver_t'(h[20:19]);
            lay  = mpeg_layer_t'(h[18:17]);
            bidx = h[15:12];
            sidx = h[11:10];
            mode = h[7:6];
            if ((h & SYNC_MASK) != SYNC_MASK || ver == VER_RSV || lay == LAYER_RSV ||
                bidx == BIDX_FREE || bidx == BIDX_BAD || sidx == SIDX_RSV)
                return info;
            v1 = (ver == VER_1);
            case (sidx)
                2'd0:    rate = 44100;
                2'd1:    rate = 48000;
                default: rate = 32000;
            endcase
            if (ver == VER_2)
                rate = rate / 2;
            else if (ver == VER_25)
                rate = rate / 4;
            case (lay)
                LAYER_1: sel = v1 ? TAB_V1_L1 : TAB_V2_L1;
                LAYER_2: sel = v1 ? TAB_V1_L2 : TAB_V2_L23;
                default: sel = v1 ? TAB_V1_L3 : TAB_V2_L23;
            endcase
            kbps = kbps_tab[sel][bidx - 1];
            // layer I counts 4-byte slots; LSF layer III has half-size frames
            if (lay == LAYER_1)
                bytes = (12000 * kbps / rate + h[9]) * 4;
            else if (lay == LAYER_2 || v1)
                bytes = 144000 * kbps / rate + h[9];
            else
                bytes = 72000 * kbps / rate + h[9];
            if (bytes > 2047)
                bytes = 2047;
            info.valid       = 1'b1;
            info.frame_bytes = bytes[FrameW-1:0];
            info.rate_hz     = rate[RateW-1:0];
            info.kbps        = kbps[KbpsW-1:0];
            info.chans       = (mode == MODE_MONO) ? CHAN_MONO : CHAN_STEREO;
            return info;
        endfunction

        function void note_header(logic [HdrW-1:0] h);
            decode_entry_t e;
            e.hdr  = h;
            e.info = decode_header(h);
            pending_q.push_back(e);
        endfunction

        function void check_result(logic tuser, logic [TdataW-1:0] tdata);
            decode_entry_t e;
            header_info_t  got;
            got.valid       = tuser;
            got.frame_bytes = tdata[10:0];
            got.rate_hz     = tdata[26:11];
            got.kbps        = tdata[35:27];
            got.chans       = tdata[37:36];
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: valid %0d bytes %0d rate %0d kbps %0d ch %0d",
                             got.valid, got.frame_bytes, got.rate_hz, got.kbps, got.chans);
                return;
            end
            e = pending_q.pop_front();
            if (got.valid !== e.info.valid || got.frame_bytes !== e.info.frame_bytes ||
                got.rate_hz !== e.info.rate_hz || got.kbps !== e.info.kbps ||
                got.chans !== e.info.chans) begin
                errors++;
                if (errors <= 10)
                    $display("hdr %h: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                             e.hdr, e.info.valid, e.info.frame_bytes, e.info.rate_hz,
                             e.info.kbps, e.info.chans, got.valid, got.frame_bytes,
                             got.rate_hz, got.kbps, got.chans);
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [HdrW-1:0]     s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TdataW-1:0]   m_axis_tdata;
    logic                m_axis_tuser;

    header_scoreboard    sb = new();
    int                  headers_accepted = 0;
    int                  cycle_count = 0;

    always #2 aclk = ~aclk;

    mpeg_audio_header_decode_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_header(s_axis_tdata);
                headers_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    function automatic logic [HdrW-1:0] pack_header(mpeg_ver_t ver, mpeg_layer_t lay,
                                                    logic [3:0] bidx, logic [1:0] sidx,
                                                    logic pad, logic [1:0] mode,
                                                    logic [31:0] filler);
        return {SYNC_MASK[31:21], ver, lay, filler[16], bidx, sidx, pad, filler[8], mode,
                filler[5:0]};
    endfunction

    function automatic logic [HdrW-1:0] random_header();
        logic [HdrW-1:0] h;
        mpeg_ver_t       ver;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return $urandom();
        case ($urandom_range(0, 2))
            0:       ver = VER_25;
            1:       ver = VER_2;
            default: ver = VER_1;
        endcase
        h = pack_header(ver, mpeg_layer_t'($urandom_range(LAYER_3, LAYER_1)),
                        4'($urandom_range(BIDX_FREE + 1, BIDX_BAD - 1)),
                        2'($urandom_range(0, SIDX_RSV - 1)), 1'($urandom()),
                        2'($urandom()), $urandom());
        if (pick < 30) begin
            case (header_fault_e'($urandom_range(BRK_SYNC, BRK_SIDX)))
                BRK_SYNC:  h[21 + $urandom_range(0, 10)] = 1'b0;
                BRK_VER:   h[20:19] = VER_RSV;
                BRK_LAYER: h[18:17] = LAYER_RSV;
                BRK_FREE:  h[15:12] = BIDX_FREE;
                BRK_BAD:   h[15:12] = BIDX_BAD;
                default:   h[11:10] = SIDX_RSV;
            endcase
        end
        return h;
    endfunction

    // holds tvalid high across back-to-back items; returns at the accepting edge
    task automatic send_header(input logic [HdrW-1:0] h);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= h;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
    endtask

    // output stall: segments of always-ready, coin flip, rotating mask, mostly stalled
    initial begin : receiver
        int          seg_left;
        int          seg_mode;
        logic [7:0]  mask;
        int          phase;
        bit          held;
        seg_left = 0;
        seg_mode = 0;
        mask     = '1;
        phase    = 0;
        held     = 0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (!held && headers_accepted >= HOLD_AFTER) begin
                held = 1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 200);
                seg_mode = $urandom_range(0, 3);
                mask     = 8'($urandom());
            end
            case (seg_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom());
                2:       m_axis_tready <= mask[phase % 8];
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
            seg_left--;
            phase++;
            @(posedge aclk);
        end
    end

    initial begin : stimulus
        int sent;
        int burst_len;
        int gap;
        sent = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // rejects: no sync, partial sync, reserved version/layer, free/bad bitrate,
        // reserved sample rate
        send_header('0);
        send_header('1);
        send_header(pack_header(VER_1, LAYER_3, 4'd9, 2'd0, 1'b0, 2'd0, '0) & ~32'h0020_0000);
        send_header(pack_header(VER_RSV, LAYER_3, 4'd9, 2'd0, 1'b0, 2'd0, '0));
        send_header(pack_header(VER_1, LAYER_RSV, 4'd9, 2'd0, 1'b0, 2'd0, '0));
        send_header(pack_header(VER_1, LAYER_3, BIDX_FREE, 2'd0, 1'b0, 2'd0, '0));
        send_header(pack_header(VER_1, LAYER_3, BIDX_BAD, 2'd0, 1'b0, 2'd0, '0));
        send_header(pack_header(VER_1, LAYER_3, 4'd9, SIDX_RSV, 1'b0, 2'd0, '0));
        // each version/layer pair, padding, mono, unexamined bits set
        send_header(pack_header(VER_1, LAYER_1, 4'd14, 2'd2, 1'b1, MODE_MONO, '1));
        send_header(pack_header(VER_1, LAYER_2, 4'd14, 2'd2, 1'b1, 2'd0, '0));
        send_header(pack_header(VER_1, LAYER_3, 4'd1, 2'd0, 1'b0, 2'd1, '1));
        send_header(pack_header(VER_2, LAYER_1, 4'd1, 2'd1, 1'b1, 2'd2, '0));
        send_header(pack_header(VER_2, LAYER_2, 4'd7, 2'd0, 1'b0, MODE_MONO, '0));
        send_header(pack_header(VER_2, LAYER_3, 4'd14, 2'd2, 1'b1, 2'd0, '1));
        send_header(pack_header(VER_25, LAYER_1, 4'd14, 2'd2, 1'b1, 2'd0, '0));
        send_header(pack_header(VER_25, LAYER_2, 4'd14, 2'd2, 1'b0, 2'd0, '0));
        send_header(pack_header(VER_25, LAYER_2, 4'd9, 2'd1, 1'b1, MODE_MONO, '1));
        send_header(pack_header(VER_25, LAYER_3, 4'd1, 2'd0, 1'b0, 2'd2, '0));
        send_header(pack_header(VER_25, LAYER_3, 4'd14, 2'd2, 1'b1, MODE_MONO, '1));
        send_header(pack_header(VER_1, LAYER_3, 4'd14, 2'd1, 1'b1, 2'd0, '0));
        sent = 20;

        while (sent < NUM_HEADERS) begin
            burst_len = $urandom_range(1, 40);
            for (int i = 0; i < burst_len && sent < NUM_HEADERS; i++) begin
                send_header(random_header());
                sent++;
            end
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom();
                repeat (gap) @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== mpeg_audio_header_decode_core.f =====
+incdir+rtl
rtl/mahd_pkg.sv
rtl/mpeg_audio_header_decode_core.sv
tb/tb_top.sv
